### rtl/core/mtmr_pkg.sv
package mtmr_pkg;

	localparam int HART_COUNT_DEF = 4;
	localparam int HART_IDX_W     = 5;
	localparam int IRQ_W          = 4;
	localparam int CFG_IDX_W      = 3;

	// function codes on the request channel
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_WRITE = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TICK       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMER_BASE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMER_SIZE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CMP_BASE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CMP_SIZE   = 3'd4;

	localparam logic [15:0] TICK_RST       = 16'd1;
	localparam logic [31:0] TIMER_BASE_RST = 32'd0;
	localparam logic [31:0] TIMER_SIZE_RST = 32'd8;
	localparam logic [31:0] CMP_BASE_RST   = 32'h0000_4000;
	localparam logic [31:0] CMP_SIZE_RST   = 32'h0000_8000;

	localparam logic [31:0] OFF_LOW  = 32'd0;
	localparam logic [31:0] OFF_HIGH = 32'd4;

	typedef enum logic [1:0] {
		OP_IDLE  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2
	} op_t;

	typedef struct packed {
		logic [15:0] tick_cycles;
		logic [31:0] timer_base;
		logic [31:0] timer_size;
		logic [31:0] cmp_base;
		logic [31:0] cmp_size;
	} cfg_t;

	typedef struct packed {
		op_t                   op;
		logic                  err;
		logic                  is_time;
		logic                  high;
		logic [HART_IDX_W-1:0] hart;
		logic [31:0]           data;
		logic [3:0]            strobe;
	} item_t;

	function automatic logic [31:0] lane_mask(input logic [3:0] strobe);
		logic [31:0] m;
		m = '0;
		for (int i = 0; i < 4; i++) begin
			if (strobe[i]) begin
				m[i*8 +: 8] = 8'hff;
			end
		end
		return m;
	endfunction

endpackage

### rtl/core/machine_timer_with_compare_irqs.sv
// Machine timer with per-hart compare interrupts.
// Request channel (req_valid/req_stall): one item per timer cycle, carrying
// func (idle, read, write), bus_address, write_data and byte_strobe. Every
// item, idle ones included, advances the prescaler and possibly the time.
// Response channel (rsp_valid/rsp_stall): one item back per request item, in
// order: response_valid, read_data, slave_error and the timer_irq bits taken
// after the item's own update.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): tick
// setting and the two address windows; write it only while the block idles.
// cfg_ready is always high.
// Each item passes through the queue, the execute stage and the result register.
// Throughput: one item per cycle while rsp_stall is low; the back end executes an
// item in its execute stage, bounded by the 64-bit time increment and half-word merge.
// A two-entry queue sits between decode and execute; when rsp_stall holds,
// the result register, the execute stage and the queue fill, and req_stall
// rises once the queue is full. The held response does not change.
// Reset clears time and prescaler, sets every compare to all ones and loads
// the configuration defaults.
module machine_timer_with_compare_irqs #(
	parameter int HART_COUNT = mtmr_pkg::HART_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [1:0]                    func,
	input  logic [31:0]                   bus_address,
	input  logic [31:0]                   write_data,
	input  logic [3:0]                    byte_strobe,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic                          response_valid,
	output logic [31:0]                   read_data,
	output logic                          slave_error,
	output logic [mtmr_pkg::IRQ_W-1:0]    timer_irq,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mtmr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);

	mtmr_pkg::cfg_t  cfg_q;
	mtmr_pkg::item_t dec_item;
	mtmr_pkg::item_t head_item;
	logic            q_full;
	logic            q_not_empty;
	logic            q_pop;
	logic            push;

	assign cfg_ready = 1'b1;
	assign req_stall = q_full;
	assign push      = req_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_cycles <= mtmr_pkg::TICK_RST;
			cfg_q.timer_base  <= mtmr_pkg::TIMER_BASE_RST;
			cfg_q.timer_size  <= mtmr_pkg::TIMER_SIZE_RST;
			cfg_q.cmp_base    <= mtmr_pkg::CMP_BASE_RST;
			cfg_q.cmp_size    <= mtmr_pkg::CMP_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mtmr_pkg::CFG_TICK:       cfg_q.tick_cycles <= cfg_data[15:0];
				mtmr_pkg::CFG_TIMER_BASE: cfg_q.timer_base  <= cfg_data;
				mtmr_pkg::CFG_TIMER_SIZE: cfg_q.timer_size  <= cfg_data;
				mtmr_pkg::CFG_CMP_BASE:   cfg_q.cmp_base    <= cfg_data;
				mtmr_pkg::CFG_CMP_SIZE:   cfg_q.cmp_size    <= cfg_data;
				default:                  cfg_q             <= cfg_q;
			endcase
		end
	end

	mtmr_front #(
		.HART_COUNT(HART_COUNT)
	) u_front (
		.cfg         (cfg_q),
		.func        (func),
		.bus_address (bus_address),
		.write_data  (write_data),
		.byte_strobe (byte_strobe),
		.item        (dec_item)
	);

	mtmr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (dec_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (head_item)
	);

	mtmr_back #(
		.HART_COUNT(HART_COUNT)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.tick_cycles    (cfg_q.tick_cycles),
		.q_valid        (q_not_empty),
		.q_item         (head_item),
		.q_pop          (q_pop),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.response_valid (response_valid),
		.read_data      (read_data),
		.slave_error    (slave_error),
		.timer_irq      (timer_irq)
	);

endmodule

### rtl/core/mtmr_front.sv
module mtmr_front #(
	parameter int HART_COUNT = mtmr_pkg::HART_COUNT_DEF
) (
	input  mtmr_pkg::cfg_t  cfg,
	input  logic [1:0]      func,
	input  logic [31:0]     bus_address,
	input  logic [31:0]     write_data,
	input  logic [3:0]      byte_strobe,
	output mtmr_pkg::item_t item
);

	localparam logic [31:0] CMP_SPAN = 32'(HART_COUNT * 8);

	logic [31:0] off_t;
	logic [31:0] off_c;
	logic        in_time;
	logic        in_cmp;
	logic        time_hit;
	logic        cmp_hit;

	always_comb begin
		off_t    = bus_address - cfg.timer_base;
		off_c    = bus_address - cfg.cmp_base;
		in_time  = off_t < cfg.timer_size;
		in_cmp   = off_c < cfg.cmp_size;
		time_hit = (off_t == mtmr_pkg::OFF_LOW) || (off_t == mtmr_pkg::OFF_HIGH);
		cmp_hit  = (off_c < CMP_SPAN) && (off_c[1:0] == 2'b00);

		unique case (func)
			mtmr_pkg::FUNC_READ:  item.op = mtmr_pkg::OP_READ;
			mtmr_pkg::FUNC_WRITE: item.op = mtmr_pkg::OP_WRITE;
			default:              item.op = mtmr_pkg::OP_IDLE;
		endcase

		// time window wins; the compare window is only looked at outside it
		item.is_time = in_time;
		item.err     = (item.op != mtmr_pkg::OP_IDLE) &&
		               !(in_time ? time_hit : (in_cmp && cmp_hit));
		item.high    = in_time ? off_t[2] : off_c[2];
		item.hart    = off_c[3 +: mtmr_pkg::HART_IDX_W];
		item.data    = write_data;
		item.strobe  = byte_strobe;
	end

endmodule

### rtl/core/mtmr_queue.sv
module mtmr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mtmr_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output mtmr_pkg::item_t head
);

	mtmr_pkg::item_t slot_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

### rtl/core/mtmr_back.sv
module mtmr_back #(
	parameter int HART_COUNT = mtmr_pkg::HART_COUNT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [15:0]                tick_cycles,
	input  logic                       q_valid,
	input  mtmr_pkg::item_t            q_item,
	output logic                       q_pop,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic                       response_valid,
	output logic [31:0]                read_data,
	output logic                       slave_error,
	output logic [mtmr_pkg::IRQ_W-1:0] timer_irq
);

	localparam int HIW = (HART_COUNT > 1) ? $clog2(HART_COUNT) : 1;

	logic [63:0] time_q;
	logic [15:0] prescale_q;
	logic [63:0] cmp_q [HART_COUNT];

	logic        vld_s1;
	logic        resp_s1;
	logic [31:0] rdata_s1;
	logic        err_s1;

	logic                       out_full_q;
	logic                       out_resp_q;
	logic [31:0]                out_rdata_q;
	logic                       out_err_q;
	logic [mtmr_pkg::IRQ_W-1:0] out_irq_q;

	logic           out_take;
	logic           out_load;
	logic           exec;
	logic [15:0]    pre_inc;
	logic           tick_hit;
	logic [15:0]    pre_next;
	logic [63:0]    time_inc;
	logic [63:0]    time_next;
	logic [HIW-1:0] hidx;
	logic           acc;
	logic           wr;
	logic [31:0]    wmask;
	logic [63:0]    cur64;
	logic [31:0]    cur32;
	logic [31:0]    new32;
	logic [63:0]    new64;
	logic [31:0]    rdata;
	logic [mtmr_pkg::IRQ_W-1:0] irq_c;

	assign out_take = out_full_q && !rsp_stall;
	assign out_load = vld_s1 && (!out_full_q || out_take);
	assign exec     = q_valid && (!vld_s1 || out_load);
	assign q_pop    = exec;

	always_comb begin
		pre_inc  = prescale_q + 16'd1;
		tick_hit = pre_inc == tick_cycles;
		pre_next = tick_hit ? 16'd0 : pre_inc;
		time_inc = time_q + {63'd0, tick_hit};

		hidx  = q_item.hart[HIW-1:0];
		acc   = (q_item.op != mtmr_pkg::OP_IDLE) && !q_item.err;
		wr    = acc && (q_item.op == mtmr_pkg::OP_WRITE);
		wmask = mtmr_pkg::lane_mask(q_item.strobe);

		// accesses see time after this item's tick
		cur64 = q_item.is_time ? time_inc : cmp_q[hidx];
		cur32 = q_item.high ? cur64[63:32] : cur64[31:0];
		new32 = (cur32 & ~wmask) | (q_item.data & wmask);
		new64 = q_item.high ? {new32, cur64[31:0]} : {cur64[63:32], new32};

		time_next = (wr && q_item.is_time) ? new64 : time_inc;
		rdata     = (acc && (q_item.op == mtmr_pkg::OP_READ)) ? cur32 : 32'd0;
	end

	// state registers hold exactly the post-item state of the item in s1
	for (genvar h = 0; h < mtmr_pkg::IRQ_W; h++) begin : g_irq
		if (h < HART_COUNT) begin : g_on
			assign irq_c[h] = time_q >= cmp_q[h];
		end else begin : g_off
			assign irq_c[h] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q     <= '0;
			prescale_q <= '0;
			for (int h = 0; h < HART_COUNT; h++) begin
				cmp_q[h] <= '1;
			end
			vld_s1     <= 1'b0;
			out_full_q <= 1'b0;
		end else begin
			if (exec) begin
				time_q     <= time_next;
				prescale_q <= pre_next;
				if (wr && !q_item.is_time) begin
					cmp_q[hidx] <= new64;
				end
			end
			if (exec) begin
				vld_s1 <= 1'b1;
			end else if (out_load) begin
				vld_s1 <= 1'b0;
			end
			if (out_load) begin
				out_full_q <= 1'b1;
			end else if (out_take) begin
				out_full_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			resp_s1  <= q_item.op != mtmr_pkg::OP_IDLE;
			rdata_s1 <= rdata;
			err_s1   <= q_item.err;
		end
		if (out_load) begin
			out_resp_q  <= resp_s1;
			out_rdata_q <= rdata_s1;
			out_err_q   <= err_s1;
			out_irq_q   <= irq_c;
		end
	end

	assign rsp_valid      = out_full_q;
	assign response_valid = out_resp_q;
	assign read_data      = out_rdata_q;
	assign slave_error    = out_err_q;
	assign timer_irq      = out_irq_q;

endmodule

### rtl/core/mtmr_checker.sv
module mtmr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic        response_valid,
	input logic [31:0] read_data,
	input logic        slave_error,
	input logic [3:0]  timer_irq,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// a held response keeps its fields
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(read_data) &&
		$stable(slave_error) && $stable(response_valid) && $stable(timer_irq))
		else $error("response changed while stalled");

	a_err_is_access: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && slave_error |-> response_valid)
		else $error("slave error on an idle item");

	a_rdata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (slave_error || !response_valid) |-> read_data == 32'd0)
		else $error("read data on error or idle item");

	// no response appears after quiet cycles in which nothing was taken in
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		(!rsp_valid && !(req_valid && !req_stall)) [*3] |=> !rsp_valid)
		else $error("response without request");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind machine_timer_with_compare_irqs mtmr_checker u_mtmr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req_valid),
	.req_stall      (req_stall),
	.rsp_valid      (rsp_valid),
	.rsp_stall      (rsp_stall),
	.response_valid (response_valid),
	.read_data      (read_data),
	.slave_error    (slave_error),
	.timer_irq      (timer_irq),
	.cfg_valid      (cfg_valid),
	.cfg_ready      (cfg_ready)
);
